### src/assert_macros.svh
// Assertion macros used by the signal pending dispatch back end.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Check a property at every rising edge outside reset.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check that a condition is followed by another in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst, prop, msg)
`define ASSERT_NEXT(lbl, clk, rst, pre, post, msg)
`endif
`endif

### src/spd_pkg.sv
// Types and constants of the signal pending dispatch unit.
package spd_pkg;

  localparam int SIG_W  = 6;
  localparam int MASK_W = 64;
  localparam int KIND_W = 3;
  localparam int HOW_W  = 2;
  localparam int DISP_W = 2;
  localparam int ACT_W  = 2;
  localparam int EXIT_W = 8;

  // Depth of the queue between front and back
  localparam int Q_DEPTH = 2;

  // Item kinds on the input port
  localparam logic [KIND_W-1:0] KIND_POST     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SELF     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_MASK     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DISP     = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DISPATCH = 3'd4;

  // Mask change modes
  localparam logic [HOW_W-1:0] HOW_BLOCK   = 2'd0;
  localparam logic [HOW_W-1:0] HOW_UNBLOCK = 2'd1;
  localparam logic [HOW_W-1:0] HOW_SET     = 2'd2;

  // Dispositions
  localparam logic [DISP_W-1:0] DISP_DEFAULT = 2'd0;
  localparam logic [DISP_W-1:0] DISP_IGNORE  = 2'd1;
  localparam logic [DISP_W-1:0] DISP_CATCH   = 2'd2;

  // Dispatch actions
  localparam logic [ACT_W-1:0] ACT_NONE    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_TERM    = 2'd1;
  localparam logic [ACT_W-1:0] ACT_HANDLER = 2'd2;

  // Status codes
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_INVAL = 1'b1;

  // Signals with fixed behaviour
  localparam logic [SIG_W-1:0] SIG_KILL  = 6'd9;
  localparam logic [SIG_W-1:0] SIG_STOP  = 6'd19;
  localparam logic [SIG_W-1:0] SIG_CHLD  = 6'd17;
  localparam logic [SIG_W-1:0] SIG_URG   = 6'd23;
  localparam logic [SIG_W-1:0] SIG_WINCH = 6'd28;

  localparam logic [EXIT_W-1:0] EXIT_BASE = 8'd128;

  // Bits that no mask change may set
  localparam logic [MASK_W-1:0] UNMASKABLE =
    (MASK_W'(1) << (SIG_KILL - 6'd1)) | (MASK_W'(1) << (SIG_STOP - 6'd1));

  // Operation decoded by the front
  typedef enum logic [2:0] {
    OP_POST,
    OP_SELF,
    OP_MASK,
    OP_DISP,
    OP_DISPATCH,
    OP_BAD
  } op_t;

  // Classified item carried through the queue
  typedef struct packed {
    op_t                op;
    logic [SIG_W-1:0]   sig;
    logic [MASK_W-1:0]  sig_bit;
    logic               sig_bad;
    logic               sig_locked;
    logic [HOW_W-1:0]   how;
    logic               change;
    logic [MASK_W-1:0]  mask;
    logic [DISP_W-1:0]  disp;
  } item_t;

  // Result of one item
  typedef struct packed {
    logic               status;
    logic               accepted;
    logic [MASK_W-1:0]  prev_mask;
    logic [DISP_W-1:0]  old_disp;
    logic [ACT_W-1:0]   action;
    logic [EXIT_W-1:0]  exit_code;
    logic [SIG_W-1:0]   sel;
  } result_t;

  // Back end sequencer states
  typedef enum logic [1:0] {
    B_IDLE,
    B_EXEC,
    B_SCAN,
    B_RESULT
  } bstate_t;

endpackage

### src/signal_pending_dispatch_unit.sv
// Top level of the signal pending dispatch unit.
// Post, self post, mask and disposition items: the back end pops the item, runs it in B_EXEC and loads
// the result register from B_RESULT. Dispatch: the back end scans 1 to NUM_SIGNALS-1 signals in B_SCAN,
// one signal a cycle through the disposition RAM read port.
// The back end takes a new item only after loading the last result; a 2-entry queue buffers input.
// Reset clears pending and blocked sets and marks every disposition default at once.
module signal_pending_dispatch_unit
  import spd_pkg::*;
#(
  parameter int NUM_SIGNALS = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [KIND_W-1:0] kind,
  input  logic [SIG_W-1:0]  signal_number,
  input  logic [HOW_W-1:0]  how,
  input  logic              change_present,
  input  logic [MASK_W-1:0] mask_value,
  input  logic [DISP_W-1:0] disposition,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              status,
  output logic              accepted,
  output logic [MASK_W-1:0] prev_mask,
  output logic [DISP_W-1:0] old_disposition,
  output logic [ACT_W-1:0]  action,
  output logic [EXIT_W-1:0] exit_code,
  output logic [SIG_W-1:0]  chosen_signal
);

  logic    q_full;
  logic    q_push;
  item_t   q_item;
  logic    q_valid;
  logic    q_pop;
  item_t   q_head;
  result_t out_data;

  spd_front #(
    .NUM_SIGNALS (NUM_SIGNALS)
  ) u_front (
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .kind           (kind),
    .signal_number  (signal_number),
    .how            (how),
    .change_present (change_present),
    .mask_value     (mask_value),
    .disposition    (disposition),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_item         (q_item)
  );

  spd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_item  (q_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  spd_back #(
    .NUM_SIGNALS (NUM_SIGNALS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Unpack the result register onto the output fields
  assign status          = out_data.status;
  assign accepted        = out_data.accepted;
  assign prev_mask       = out_data.prev_mask;
  assign old_disposition = out_data.old_disp;
  assign action          = out_data.action;
  assign exit_code       = out_data.exit_code;
  assign chosen_signal   = out_data.sel;

endmodule

### src/spd_ram.sv
// Generic single write port RAM with registered read.
module spd_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/spd_front.sv
// Front end: input handshake and classification of items.
module spd_front
  import spd_pkg::*;
#(
  parameter int NUM_SIGNALS = 64
) (
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [KIND_W-1:0] kind,
  input  logic [SIG_W-1:0]  signal_number,
  input  logic [HOW_W-1:0]  how,
  input  logic              change_present,
  input  logic [MASK_W-1:0] mask_value,
  input  logic [DISP_W-1:0] disposition,
  input  logic              q_full,
  output logic              q_push,
  output item_t             q_item
);

  // Take a transfer whenever the queue has room
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  // Decode kind, check the signal number, strip unmaskable bits and clamp the disposition
  always_comb begin
    case (kind)
      KIND_POST:     q_item.op = OP_POST;
      KIND_SELF:     q_item.op = OP_SELF;
      KIND_MASK:     q_item.op = OP_MASK;
      KIND_DISP:     q_item.op = OP_DISP;
      KIND_DISPATCH: q_item.op = OP_DISPATCH;
      default:       q_item.op = OP_BAD;
    endcase
    q_item.sig        = signal_number;
    q_item.sig_bit    = MASK_W'(1) << (signal_number - 6'd1);
    q_item.sig_bad    = (signal_number == '0) ||
                        ({1'b0, signal_number} >= (SIG_W + 1)'(NUM_SIGNALS));
    q_item.sig_locked = (signal_number == SIG_KILL) || (signal_number == SIG_STOP);
    q_item.how        = how;
    q_item.change     = change_present;
    q_item.mask       = mask_value & ~UNMASKABLE;
    q_item.disp       = (disposition >= DISP_CATCH) ? DISP_CATCH : disposition;
  end

endmodule

### src/spd_queue.sv
// Short queue of classified items between front and back.
module spd_queue
  import spd_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  head_valid,
  output item_t head
);

  localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CW = $clog2(Q_DEPTH + 1);

  item_t          entries [Q_DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign full       = (count == CW'(Q_DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];

  // Store pushed items
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // Advance pointers and track fill
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(Q_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(Q_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

### src/spd_back.sv
// Back end: executes items against the signal state and drives results.
`include "assert_macros.svh"
module spd_back
  import spd_pkg::*;
#(
  parameter int NUM_SIGNALS = 64
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    q_valid,
  input  item_t   q_head,
  output logic    q_pop,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  localparam int AW = $clog2(NUM_SIGNALS);
  localparam int VD = 1 << AW;
  localparam logic [SIG_W-1:0] SIG_LAST = SIG_W'(NUM_SIGNALS - 1);

  bstate_t           state;
  bstate_t           state_next;
  item_t             w;
  result_t           res;
  result_t           res_next;
  logic [MASK_W-1:0] pending;
  logic [MASK_W-1:0] pending_next;
  logic [MASK_W-1:0] blocked;
  logic [MASK_W-1:0] blocked_next;
  logic [SIG_W-1:0]  scan_sig;
  logic [VD-1:0]     disp_valid;
  logic              rd_valid;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [DISP_W-1:0] ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [DISP_W-1:0] ram_rdata;
  logic [DISP_W-1:0] disp_value;

  logic              out_free;
  logic              out_load;
  logic [SIG_W-1:0]  scan_idx;
  logic [SIG_W-1:0]  scan_succ;
  logic [MASK_W-1:0] scan_bit;
  logic              scan_pend;
  logic              scan_live;
  logic              scan_catch;
  logic              scan_fatal;
  logic              stop_hit;
  logic              scan_end;

  spd_ram #(
    .WIDTH (DISP_W),
    .DEPTH (NUM_SIGNALS)
  ) u_disp_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Entries never written read as default
  assign disp_value = rd_valid ? ram_rdata : DISP_DEFAULT;

  // Evaluate the signal under the scan
  assign scan_idx   = scan_sig - 6'd1;
  assign scan_succ  = scan_sig + 6'd1;
  assign scan_bit   = MASK_W'(1) << scan_idx;
  assign scan_pend  = pending[scan_idx];
  assign scan_live  = scan_pend && !blocked[scan_idx];
  assign scan_catch = (disp_value == DISP_CATCH);
  assign scan_fatal = (disp_value == DISP_DEFAULT) && (scan_sig != SIG_CHLD) &&
                      (scan_sig != SIG_URG) && (scan_sig != SIG_WINCH);
  assign stop_hit   = scan_live && (scan_catch || scan_fatal);
  assign scan_end   = stop_hit || (scan_sig == SIG_LAST);

  assign out_free = !out_valid || out_ready;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (q_valid) begin
          state_next = (q_head.op == OP_DISPATCH) ? B_SCAN : B_EXEC;
        end
      end
      B_EXEC: state_next = B_RESULT;
      B_SCAN: begin
        if (scan_end) begin
          state_next = B_RESULT;
        end
      end
      B_RESULT: begin
        if (out_free) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  // Control outputs of the sequencer
  always_comb begin
    q_pop     = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = scan_succ[AW-1:0];
    ram_we    = 1'b0;
    out_load  = 1'b0;
    case (state)
      B_IDLE: begin
        q_pop     = q_valid;
        ram_re    = q_valid;
        ram_raddr = (q_head.op == OP_DISPATCH) ? AW'(1) : q_head.sig[AW-1:0];
      end
      B_EXEC: ram_we = (w.op == OP_DISP) && !w.sig_bad && !w.sig_locked && w.change;
      B_SCAN: ram_re = !scan_end;
      B_RESULT: out_load = out_free;
      default: ;
    endcase
  end

  assign ram_waddr = w.sig[AW-1:0];
  assign ram_wdata = w.disp;

  // Work out the item result and set updates
  always_comb begin
    pending_next = pending;
    blocked_next = blocked;
    res_next     = res;
    case (state)
      B_IDLE: res_next = '0;
      B_EXEC: begin
        res_next = '0;
        case (w.op)
          OP_POST: begin
            if (w.sig_bad) begin
              res_next.status = STATUS_INVAL;
            end else begin
              pending_next = pending | w.sig_bit;
            end
          end
          OP_SELF: begin
            if (w.sig_bad) begin
              res_next.status = STATUS_INVAL;
            end else if (((blocked & w.sig_bit) == '0) && (disp_value != DISP_IGNORE)) begin
              pending_next      = pending | w.sig_bit;
              res_next.accepted = 1'b1;
            end
          end
          OP_MASK: begin
            res_next.prev_mask = blocked;
            if (w.change) begin
              case (w.how)
                HOW_BLOCK:   blocked_next = blocked | w.mask;
                HOW_UNBLOCK: blocked_next = blocked & ~w.mask;
                HOW_SET:     blocked_next = w.mask;
                default:     res_next.status = STATUS_INVAL;
              endcase
            end
          end
          OP_DISP: begin
            if (w.sig_bad || (w.change && w.sig_locked)) begin
              res_next.status = STATUS_INVAL;
            end else begin
              res_next.old_disp = disp_value;
            end
          end
          default: res_next.status = STATUS_INVAL;
        endcase
      end
      B_SCAN: begin
        if (scan_pend) begin
          pending_next = pending & ~scan_bit;
        end
        if (stop_hit) begin
          res_next.sel = scan_sig;
          if (scan_catch) begin
            res_next.action = ACT_HANDLER;
          end else begin
            res_next.action    = ACT_TERM;
            res_next.exit_code = EXIT_BASE + {2'b00, scan_sig};
          end
        end
      end
      default: ;
    endcase
  end

  // Hold the working item and the result
  always_ff @(posedge clk) begin
    if (q_pop) begin
      w <= q_head;
    end
    res <= res_next;
    if (out_load) begin
      out_data <= res;
    end
  end

  // Sequencer, signal sets, scan position and read tags
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_IDLE;
      pending    <= '0;
      blocked    <= '0;
      scan_sig   <= SIG_W'(1);
      disp_valid <= '0;
      rd_valid   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state   <= state_next;
      pending <= pending_next;
      blocked <= blocked_next;
      if (q_pop) begin
        scan_sig <= SIG_W'(1);
      end else if (state == B_SCAN && !scan_end) begin
        scan_sig <= scan_succ;
      end
      if (ram_we) begin
        disp_valid[ram_waddr] <= 1'b1;
      end
      if (ram_re) begin
        rd_valid <= disp_valid[ram_raddr];
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `ASSERT_NEXT(a_pop_leaves_idle, clk, rst, q_pop, state != B_IDLE, "pop did not start work")
  `ASSERT_NEXT(a_scan_no_gain, clk, rst, state == B_SCAN, (pending & ~$past(pending)) == '0, "pending grew during dispatch scan")
  `ASSERT_CLK(a_term_exit, clk, rst, (out_load && res.action == ACT_TERM) |-> (res.exit_code == EXIT_BASE + {2'b00, res.sel}), "exit code does not match signal")
  `ASSERT_CLK(a_wdata_legal, clk, rst, ram_we |-> (ram_wdata <= DISP_CATCH), "illegal disposition written")

endmodule

### dv/signal_pending_dispatch_unit_test.sv
// Self-checking testbench for the signal pending dispatch unit.
module signal_pending_dispatch_unit_test
  import spd_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SIG_COUNT        = 64;
  localparam int CYCLE_LIMIT      = 300000;
  localparam int DRAIN_CYCLES     = 100;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int MAX_PRINTS       = 40;

  // Codes the package leaves unnamed
  localparam logic [KIND_W-1:0] KIND_UNUSED_LO = 3'd5;
  localparam logic [KIND_W-1:0] KIND_UNUSED_HI = 3'd7;
  localparam logic [HOW_W-1:0]  HOW_BAD        = 2'd3;
  localparam logic [DISP_W-1:0] DISP_OVERRANGE = 2'd3;
  localparam logic [SIG_W-1:0]  SIG_NONE       = 6'd0;
  localparam logic [SIG_W-1:0]  SIG_TOP        = 6'd63;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [KIND_W-1:0] kind = '0;
  logic [SIG_W-1:0]  signal_number = '0;
  logic [HOW_W-1:0]  how = '0;
  logic              change_present = 1'b0;
  logic [MASK_W-1:0] mask_value = '0;
  logic [DISP_W-1:0] disposition = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              status;
  logic              accepted;
  logic [MASK_W-1:0] prev_mask;
  logic [DISP_W-1:0] old_disposition;
  logic [ACT_W-1:0]  action;
  logic [EXIT_W-1:0] exit_code;
  logic [SIG_W-1:0]  chosen_signal;

  // Predicted task signal state
  logic [MASK_W-1:0] pending_bits = '0;
  logic [MASK_W-1:0] blocked_bits = '0;
  logic [DISP_W-1:0] handling_table [SIG_COUNT];

  result_t expected_outcomes [$];
  int      mismatch_count = 0;
  int      cycle_count = 0;
  bit      sender_idle_en = 1'b1;
  bit      receiver_idle_en = 1'b1;
  bit      long_hold_req = 1'b0;

  signal_pending_dispatch_unit #(
    .NUM_SIGNALS(SIG_COUNT)
  ) DUT (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .kind           (kind),
    .signal_number  (signal_number),
    .how            (how),
    .change_present (change_present),
    .mask_value     (mask_value),
    .disposition    (disposition),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .accepted       (accepted),
    .prev_mask      (prev_mask),
    .old_disposition(old_disposition),
    .action         (action),
    .exit_code      (exit_code),
    .chosen_signal  (chosen_signal)
  );

  always begin
    #5;
    clk = 1'b1;
    #5;
    clk = 1'b0;
  end

  initial begin
    foreach (handling_table[i]) handling_table[i] = DISP_DEFAULT;
  end

  // Advance the predicted state by one item and return its outcome
  function automatic result_t apply_signal_item(input logic [KIND_W-1:0] k,
                                                input logic [SIG_W-1:0] s,
                                                input logic [HOW_W-1:0] h,
                                                input logic chg,
                                                input logic [MASK_W-1:0] m,
                                                input logic [DISP_W-1:0] d);
    result_t           r;
    logic [MASK_W-1:0] cleaned;
    logic              sig_valid;
    logic              done;
    int                idx;
    int                n;
    r = '0;
    idx = int'(s) - 1;
    sig_valid = (s != SIG_NONE) && (int'(s) < SIG_COUNT);
    case (k)
      KIND_POST: begin
        if (!sig_valid) r.status = STATUS_INVAL;
        else pending_bits[idx] = 1'b1;
      end
      KIND_SELF: begin
        if (!sig_valid) begin
          r.status = STATUS_INVAL;
        end else if (!blocked_bits[idx] && handling_table[s] != DISP_IGNORE) begin
          pending_bits[idx] = 1'b1;
          r.accepted = 1'b1;
        end
      end
      KIND_MASK: begin
        r.prev_mask = blocked_bits;
        if (chg) begin
          // Kill and stop can never be blocked
          cleaned = m;
          cleaned[SIG_KILL - 1] = 1'b0;
          cleaned[SIG_STOP - 1] = 1'b0;
          case (h)
            HOW_BLOCK:   blocked_bits = blocked_bits | cleaned;
            HOW_UNBLOCK: blocked_bits = blocked_bits & ~cleaned;
            HOW_SET:     blocked_bits = cleaned;
            default:     r.status = STATUS_INVAL;
          endcase
        end
      end
      KIND_DISP: begin
        if (!sig_valid || (chg && (s == SIG_KILL || s == SIG_STOP))) begin
          r.status = STATUS_INVAL;
        end else begin
          r.old_disp = handling_table[s];
          if (chg) handling_table[s] = (d >= DISP_CATCH) ? DISP_CATCH : d;
        end
      end
      KIND_DISPATCH: begin
        // Walk pending from the lowest signal, clearing each one visited
        done = 1'b0;
        for (n = 1; n < SIG_COUNT; n++) begin
          if (!done && pending_bits[n-1]) begin
            pending_bits[n-1] = 1'b0;
            if (!blocked_bits[n-1] && handling_table[n] != DISP_IGNORE) begin
              if (handling_table[n] == DISP_CATCH) begin
                r.action = ACT_HANDLER;
                r.sel = SIG_W'(n);
                done = 1'b1;
              end else if (n != SIG_CHLD && n != SIG_URG && n != SIG_WINCH) begin
                r.action = ACT_TERM;
                r.exit_code = EXIT_BASE + EXIT_W'(n);
                r.sel = SIG_W'(n);
                done = 1'b1;
              end
            end
          end
        end
      end
      default: r.status = STATUS_INVAL;
    endcase
    return r;
  endfunction

  function automatic logic [MASK_W-1:0] random_mask();
    return {$urandom, $urandom};
  endfunction

  // Bias towards the signals with fixed behaviour, the top signal and the invalid one
  function automatic logic [SIG_W-1:0] pick_signal();
    int c;
    c = $urandom_range(0, 19);
    case (c)
      0:       return SIG_NONE;
      1:       return SIG_KILL;
      2:       return SIG_STOP;
      3:       return SIG_CHLD;
      4:       return SIG_URG;
      5:       return SIG_WINCH;
      6:       return SIG_TOP;
      default: return SIG_W'($urandom_range(1, 63));
    endcase
  endfunction

  function automatic logic [MASK_W-1:0] pick_mask();
    case ($urandom_range(0, 4))
      0:       return random_mask();
      1:       return random_mask() & random_mask() & random_mask();
      2:       return '1;
      3:       return '0;
      default: return MASK_W'(1) << $urandom_range(0, 63);
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [MASK_W-1:0] got,
                                 input logic [MASK_W-1:0] want);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS)
      $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
  endtask

  // Offer one item, hold it until transfer, then record its outcome
  task automatic offer_signal_item(input logic [KIND_W-1:0] k, input logic [SIG_W-1:0] s,
                                   input logic [HOW_W-1:0] h, input logic chg,
                                   input logic [MASK_W-1:0] m, input logic [DISP_W-1:0] d);
    in_valid       <= 1'b1;
    kind           <= k;
    signal_number  <= s;
    how            <= h;
    change_present <= chg;
    mask_value     <= m;
    disposition    <= d;
    do @(posedge clk); while (!in_ready);
    expected_outcomes.push_back(apply_signal_item(k, s, h, chg, m, d));
    if (sender_idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic offer_random_item();
    int                pick;
    logic [KIND_W-1:0] k;
    logic [HOW_W-1:0]  h;
    logic              chg;
    logic [MASK_W-1:0] m;
    pick = $urandom_range(0, 99);
    h = HOW_W'($urandom_range(0, 3));
    chg = 1'($urandom_range(0, 1));
    m = random_mask();
    if (pick < 30) begin
      k = KIND_POST;
    end else if (pick < 42) begin
      k = KIND_SELF;
    end else if (pick < 55) begin
      k = KIND_MASK;
      chg = ($urandom_range(0, 4) != 0);
      h = ($urandom_range(0, 9) == 0) ? HOW_BAD : HOW_W'($urandom_range(0, 2));
      m = pick_mask();
    end else if (pick < 70) begin
      k = KIND_DISP;
      chg = ($urandom_range(0, 3) != 0);
    end else if (pick < 97) begin
      k = KIND_DISPATCH;
    end else begin
      k = KIND_W'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
    end
    offer_signal_item(k, pick_signal(), h, chg, m, DISP_W'($urandom_range(0, 3)));
  endtask

  task automatic test_invalid_signals();
    offer_signal_item(KIND_POST, SIG_NONE, HOW_BLOCK, 1'b0, '0, DISP_DEFAULT);
    offer_signal_item(KIND_SELF, SIG_NONE, HOW_BLOCK, 1'b0, '0, DISP_DEFAULT);
    offer_signal_item(KIND_DISP, SIG_NONE, HOW_BLOCK, 1'b1, '0, DISP_CATCH);
  endtask

  task automatic test_unknown_kinds();
    int k;
    for (k = KIND_UNUSED_LO; k <= KIND_UNUSED_HI; k++)
      offer_signal_item(KIND_W'(k), pick_signal(), HOW_W'($urandom_range(0, 3)), 1'b1,
                        random_mask(), DISP_W'($urandom_range(0, 3)));
  endtask

  task automatic test_mask_changes();
    // Query only: how is not looked at
    offer_signal_item(KIND_MASK, SIG_NONE, HOW_BAD, 1'b0, '1, DISP_DEFAULT);
    offer_signal_item(KIND_MASK, SIG_NONE, HOW_BLOCK, 1'b1, '1, DISP_DEFAULT);
    offer_signal_item(KIND_MASK, SIG_NONE, HOW_UNBLOCK, 1'b1, 64'h5555_5555_5555_5555,
                      DISP_DEFAULT);
    // Bad mode: old mask reported, blocked set kept
    offer_signal_item(KIND_MASK, SIG_NONE, HOW_BAD, 1'b1, '0, DISP_DEFAULT);
    // Leave signal 3 and the top bit blocked
    offer_signal_item(KIND_MASK, SIG_NONE, HOW_SET, 1'b1, 64'h8000_0000_0000_0004,
                      DISP_DEFAULT);
  endtask

  task automatic test_disposition_changes();
    offer_signal_item(KIND_DISP, SIG_KILL, HOW_BLOCK, 1'b1, '0, DISP_CATCH);
    offer_signal_item(KIND_DISP, SIG_STOP, HOW_BLOCK, 1'b0, '0, DISP_IGNORE);
    // Code three lands as catch
    offer_signal_item(KIND_DISP, 6'd5, HOW_BLOCK, 1'b1, '0, DISP_OVERRANGE);
    offer_signal_item(KIND_DISP, 6'd10, HOW_BLOCK, 1'b1, '0, DISP_IGNORE);
  endtask

  task automatic test_dispatch_cases();
    offer_signal_item(KIND_DISPATCH, SIG_NONE, HOW_BLOCK, 1'b0, '0, DISP_DEFAULT);
    offer_signal_item(KIND_POST, SIG_CHLD, HOW_BLOCK, 1'b0, '0, DISP_DEFAULT);
    offer_signal_item(KIND_POST, SIG_URG, HOW_BLOCK, 1'b0, '0, DISP_DEFAULT);
    offer_signal_item(KIND_POST, SIG_WINCH, HOW_BLOCK, 1'b0, '0, DISP_DEFAULT);
    // Ignored signal: self post refused
    offer_signal_item(KIND_SELF, 6'd10, HOW_BLOCK, 1'b0, '0, DISP_DEFAULT);
    offer_signal_item(KIND_POST, SIG_TOP, HOW_BLOCK, 1'b0, '0, DISP_DEFAULT);
    offer_signal_item(KIND_POST, 6'd5, HOW_BLOCK, 1'b0, '0, DISP_DEFAULT);
    // Handler for 5, everything above stays pending
    offer_signal_item(KIND_DISPATCH, SIG_TOP, HOW_BAD, 1'b1, '1, DISP_CATCH);
    // Default-ignored ones dropped, then terminate on the top signal
    offer_signal_item(KIND_DISPATCH, SIG_NONE, HOW_BLOCK, 1'b0, '0, DISP_DEFAULT);
    // Blocked signal: self post refused, plain post discarded by dispatch
    offer_signal_item(KIND_SELF, 6'd3, HOW_BLOCK, 1'b0, '0, DISP_DEFAULT);
    offer_signal_item(KIND_POST, 6'd3, HOW_BLOCK, 1'b0, '0, DISP_DEFAULT);
    offer_signal_item(KIND_DISPATCH, SIG_NONE, HOW_BLOCK, 1'b0, '0, DISP_DEFAULT);
  endtask

  task automatic test_backpressure();
    sender_idle_en = 1'b0;
    long_hold_req = 1'b1;
    repeat (20) offer_random_item();
    sender_idle_en = 1'b1;
  endtask

  task automatic test_random_traffic();
    repeat (450) offer_random_item();
  endtask

  task automatic test_steady_stream();
    sender_idle_en = 1'b0;
    receiver_idle_en = 1'b0;
    repeat (50) offer_random_item();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_invalid_signals();
    test_unknown_kinds();
    test_mask_changes();
    test_disposition_changes();
    test_dispatch_cases();
    test_backpressure();
    test_random_traffic();
    test_steady_stream();
    in_valid <= 1'b0;
    while (expected_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("signal_pending_dispatch_unit regression: pass");
    end else begin
      $display("signal_pending_dispatch_unit regression: fail");
    end
    $finish;
  end

  // Drive the result side: long hold on request, short random stalls, ready runs
  initial begin
    while (rst) @(posedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end else if (receiver_idle_en && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  // Compare each result transfer against the oldest prediction
  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_outcomes.size() == 0) begin
        report_mismatch("result with nothing expected", prev_mask, '0);
      end else begin
        want = expected_outcomes.pop_front();
        if (status !== want.status)
          report_mismatch("status", MASK_W'(status), MASK_W'(want.status));
        if (accepted !== want.accepted)
          report_mismatch("accepted", MASK_W'(accepted), MASK_W'(want.accepted));
        if (prev_mask !== want.prev_mask)
          report_mismatch("prev_mask", prev_mask, want.prev_mask);
        if (old_disposition !== want.old_disp)
          report_mismatch("old_disposition", MASK_W'(old_disposition),
                          MASK_W'(want.old_disp));
        if (action !== want.action)
          report_mismatch("action", MASK_W'(action), MASK_W'(want.action));
        if (exit_code !== want.exit_code)
          report_mismatch("exit_code", MASK_W'(exit_code), MASK_W'(want.exit_code));
        if (chosen_signal !== want.sel)
          report_mismatch("chosen_signal", MASK_W'(chosen_signal), MASK_W'(want.sel));
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("signal_pending_dispatch_unit regression: fail");
      $finish;
    end
  end

endmodule

### files.f
+incdir+src
src/spd_pkg.sv
src/spd_ram.sv
src/spd_front.sv
src/spd_queue.sv
src/spd_back.sv
src/signal_pending_dispatch_unit.sv
dv/signal_pending_dispatch_unit_test.sv
